### rtl/iprt_pkg.sv
// ----------------------------------------------------------------------------
// iprt_pkg
// shared types and constants of the ipv4 longest-prefix-match route table
// ----------------------------------------------------------------------------
package iprt_pkg;

  localparam int ROUTE_ENTRIES_DEF  = 32;
  localparam int DEVICE_ID_BITS_DEF = 4;

  localparam int ADDR_W   = 32;
  localparam int METRIC_W = 32;
  localparam int FLAGS_W  = 16;
  localparam int DEV_W    = 4;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 6;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_ROUTE  = 2'd3;

  // route flag bit positions
  localparam int FLAG_UP_BIT     = 0;
  localparam int FLAG_GATEWAY_BIT = 1;
  localparam int FLAG_REJECT_BIT = 9;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   key_address;
    logic [ADDR_W-1:0]   prefix_mask;
    logic [ADDR_W-1:0]   gateway_address;
    logic [DEV_W-1:0]    device_id;
    logic [METRIC_W-1:0] route_metric;
    logic [FLAGS_W-1:0]  route_flags;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] next_hop;
    logic [DEV_W-1:0]  out_device;
  } rsp_t;

  // sequencer to evaluator
  typedef struct packed {
    logic start;   // new request, clear the running picks
    logic rd_vld;  // table read data valid this cycle
  } eval_ctl_t;

  // evaluator to sequencer
  typedef struct packed {
    logic busy;      // compare stage still holds an entry
    logic add_hit;   // valid entry with same network and mask
    logic free_hit;  // some free slot seen
    logic del_hit;   // entry to delete seen
    logic lk_hit;    // lookup found a route
  } eval_flags_t;

endpackage

### rtl/ip_route_table_lpm_top.sv
// ----------------------------------------------------------------------------
// ip_route_table_lpm_top
// ipv4 route table with add, delete and longest-prefix-match lookup
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload | carries
//  --------+------------------------+---------+--------------------------------
//  request | req_valid / req_ready  | req     | command, address, mask, route
//  result  | rsp_valid / rsp_ready  | rsp     | status, next hop, device
//
// - every request scans the whole table, one entry per cycle out of the entry
//   ram; a transfer passes through the scan, the ram read, the compare stage,
//   the select stage and the idle slot
// - after reset the valid ram is swept to zero, and req_ready stays low until
//   the sweep ends
// - a finished result sits in the rsp register; the next request is taken
//   while it waits, and only the write back of a second result stalls on it
// - table writes (add, delete) happen in the same cycle the result is loaded
//
module ip_route_table_lpm_top import iprt_pkg::*; #(
  parameter int ROUTE_ENTRIES  = ROUTE_ENTRIES_DEF,
  parameter int DEVICE_ID_BITS = DEVICE_ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IW     = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW     = $clog2(ROUTE_ENTRIES + 1);
  localparam int DATA_W = 3 * ADDR_W + METRIC_W + FLAGS_W + DEVICE_ID_BITS;
  localparam logic [CW-1:0] LAST = CW'(ROUTE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;        // sweep / scan position
  req_t          req_q;      // request under work
  logic          rd_vld;     // ram read data valid
  logic [IW-1:0] rd_idx;     // entry index of the read data

  // ram ports
  logic              vram_we, vram_wdata, vram_rdata;
  logic [IW-1:0]     vram_waddr;
  logic              dram_we;
  logic [IW-1:0]     dram_waddr;
  logic [DATA_W-1:0] dram_wdata, dram_rdata;
  logic              ram_re;

  // evaluator
  eval_ctl_t                 ev_ctl;
  eval_flags_t               ev_flags;
  logic [IW-1:0]             add_idx, free_idx, del_idx;
  logic [ADDR_W-1:0]         lk_hop;
  logic [DEVICE_ID_BITS-1:0] lk_dev;

  logic req_xfer, fin_go;
  rsp_t rsp_next;
  logic tbl_we_valid, tbl_we_data, tbl_vbit;
  logic [IW-1:0] tbl_idx;

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;

  // finish once the compare pipe is empty and the result register is free
  assign fin_go = (state == S_FINISH) && !rd_vld && !ev_flags.busy &&
                  (!rsp_valid || rsp_ready);

  assign ev_ctl.start  = req_xfer;
  assign ev_ctl.rd_vld = rd_vld;

  // result and table update of the finished request
  always_comb begin
    rsp_next     = '0;
    tbl_we_valid = 1'b0;
    tbl_we_data  = 1'b0;
    tbl_vbit     = 1'b0;
    tbl_idx      = add_idx;
    unique case (req_q.cmd)
      CMD_LOOKUP: begin
        if (ev_flags.lk_hit) begin
          rsp_next.status     = ST_OK;
          rsp_next.next_hop   = lk_hop;
          rsp_next.out_device = DEV_W'(lk_dev);
        end else begin
          rsp_next.status   = ST_NO_ROUTE;
          rsp_next.next_hop = req_q.key_address;
        end
      end
      CMD_ADD: begin
        // update the matching route, else take the lowest free slot
        if (ev_flags.add_hit || ev_flags.free_hit) begin
          rsp_next.status = ST_OK;
          tbl_we_valid    = 1'b1;
          tbl_we_data     = 1'b1;
          tbl_vbit        = 1'b1;
          tbl_idx         = ev_flags.add_hit ? add_idx : free_idx;
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (ev_flags.del_hit) begin
          rsp_next.status = ST_OK;
          tbl_we_valid    = 1'b1;
          tbl_idx         = del_idx;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // unused command leaves the table alone
        rsp_next.status = ST_OK;
      end
    endcase
  end

  // ram port muxing: reset sweep owns the valid ram while it runs
  assign ram_re     = (state == S_SCAN);
  assign vram_we    = (state == S_CLEAR) || (fin_go && tbl_we_valid);
  assign vram_waddr = (state == S_CLEAR) ? cnt[IW-1:0] : tbl_idx;
  assign vram_wdata = (state == S_CLEAR) ? 1'b0 : tbl_vbit;

  assign dram_we    = fin_go && tbl_we_data;
  assign dram_waddr = tbl_idx;
  assign dram_wdata = {req_q.key_address, req_q.prefix_mask, req_q.gateway_address,
                       req_q.route_metric, req_q.route_flags,
                       DEVICE_ID_BITS'(req_q.device_id)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN);
      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_IDLE: begin
          if (req_xfer) begin
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + CW'(1);
          if (cnt == LAST) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase

      if (fin_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end

    // payload registers
    rd_idx <= cnt[IW-1:0];
    if (req_xfer) begin
      req_q <= req;
    end
    if (fin_go) begin
      rsp <= rsp_next;
    end
  end

  iprt_ram #(
    .WIDTH (1),
    .DEPTH (ROUTE_ENTRIES)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (ram_re),
    .raddr (cnt[IW-1:0]),
    .rdata (vram_rdata)
  );

  iprt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROUTE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (dram_wdata),
    .re    (ram_re),
    .raddr (cnt[IW-1:0]),
    .rdata (dram_rdata)
  );

  iprt_eval #(
    .ROUTE_ENTRIES  (ROUTE_ENTRIES),
    .DEVICE_ID_BITS (DEVICE_ID_BITS)
  ) u_eval (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ev_ctl),
    .rd_idx       (rd_idx),
    .rd_valid_bit (vram_rdata),
    .rd_data      (dram_rdata),
    .req          (req_q),
    .flags        (ev_flags),
    .add_idx      (add_idx),
    .free_idx     (free_idx),
    .del_idx      (del_idx),
    .lk_hop       (lk_hop),
    .lk_dev       (lk_dev)
  );

endmodule

### rtl/iprt_ram.sv
// ----------------------------------------------------------------------------
// iprt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module iprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/iprt_eval.sv
// ----------------------------------------------------------------------------
// iprt_eval
// per-entry compare stage and running selection of add, delete and lookup picks
// ----------------------------------------------------------------------------
module iprt_eval import iprt_pkg::*; #(
  parameter int ROUTE_ENTRIES  = ROUTE_ENTRIES_DEF,
  parameter int DEVICE_ID_BITS = DEVICE_ID_BITS_DEF,
  parameter int IW             = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
  parameter int DATA_W         = 3 * ADDR_W + METRIC_W + FLAGS_W + DEVICE_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  eval_ctl_t                 ctl,
  input  logic [IW-1:0]             rd_idx,
  input  logic                      rd_valid_bit,
  input  logic [DATA_W-1:0]         rd_data,
  input  req_t                      req,
  output eval_flags_t               flags,
  output logic [IW-1:0]             add_idx,
  output logic [IW-1:0]             free_idx,
  output logic [IW-1:0]             del_idx,
  output logic [ADDR_W-1:0]         lk_hop,
  output logic [DEVICE_ID_BITS-1:0] lk_dev
);

  localparam int FLG_LSB = DEVICE_ID_BITS;
  localparam int MET_LSB = FLG_LSB + FLAGS_W;
  localparam int GW_LSB  = MET_LSB + METRIC_W;
  localparam int MSK_LSB = GW_LSB + ADDR_W;
  localparam int NET_LSB = MSK_LSB + ADDR_W;

  // leading ones of a mask, halving search
  function automatic logic [LEN_W-1:0] lead_ones(input logic [ADDR_W-1:0] m);
    logic [LEN_W-1:0]  n;
    logic [ADDR_W-1:0] v;
    n = '0;
    v = m;
    if (&v[31:16]) begin n = n + LEN_W'(16); v = v << 16; end
    if (&v[31:24]) begin n = n + LEN_W'(8);  v = v << 8;  end
    if (&v[31:28]) begin n = n + LEN_W'(4);  v = v << 4;  end
    if (&v[31:30]) begin n = n + LEN_W'(2);  v = v << 2;  end
    if (v[31])     begin n = n + LEN_W'(1);  v = v << 1;  end
    if (v[31])     begin n = n + LEN_W'(1);  end
    return n;
  endfunction

  logic [ADDR_W-1:0]         e_net, e_mask, e_gw;
  logic [METRIC_W-1:0]       e_metric;
  logic [FLAGS_W-1:0]        e_flags;
  logic [DEVICE_ID_BITS-1:0] e_dev;

  assign e_dev    = rd_data[DEVICE_ID_BITS-1:0];
  assign e_flags  = rd_data[FLG_LSB +: FLAGS_W];
  assign e_metric = rd_data[MET_LSB +: METRIC_W];
  assign e_gw     = rd_data[GW_LSB +: ADDR_W];
  assign e_mask   = rd_data[MSK_LSB +: ADDR_W];
  assign e_net    = rd_data[NET_LSB +: ADDR_W];

  // compare stage registers
  logic                      a_vld;
  logic                      a_hit, a_free, a_del, a_lk;
  logic [LEN_W-1:0]          a_len;
  logic [METRIC_W-1:0]       a_metric;
  logic [ADDR_W-1:0]         a_hop;
  logic [DEVICE_ID_BITS-1:0] a_dev;
  logic [IW-1:0]             a_idx;

  logic hit_c;
  assign hit_c = rd_valid_bit && (e_net == req.key_address) && (e_mask == req.prefix_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= ctl.rd_vld;
    end
    a_hit    <= hit_c;
    a_free   <= !rd_valid_bit;
    a_del    <= hit_c && ((req.gateway_address == '0) || (e_gw == req.gateway_address));
    a_lk     <= rd_valid_bit && e_flags[FLAG_UP_BIT] && !e_flags[FLAG_REJECT_BIT] &&
                ((req.key_address & e_mask) == e_net);
    a_len    <= lead_ones(e_mask);
    a_metric <= e_metric;
    a_hop    <= e_flags[FLAG_GATEWAY_BIT] ? e_gw : req.key_address;
    a_dev    <= e_dev;
    a_idx    <= rd_idx;
  end

  // running picks
  logic                add_hit, free_hit, del_hit, lk_hit;
  logic [LEN_W-1:0]    best_len;
  logic [METRIC_W-1:0] win_metric;

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      add_hit  <= 1'b0;
      free_hit <= 1'b0;
      del_hit  <= 1'b0;
      lk_hit   <= 1'b0;
    end else if (a_vld) begin
      if (a_hit && !add_hit) begin
        add_hit <= 1'b1;
        add_idx <= a_idx;
      end
      if (a_free && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= a_idx;
      end
      if (a_del && !del_hit) begin
        del_hit <= 1'b1;
        del_idx <= a_idx;
      end
      // longer prefix wins, then lower metric, then lower index
      if (a_lk && (!lk_hit || (a_len > best_len) ||
                   ((a_len == best_len) && (a_metric < win_metric)))) begin
        lk_hit     <= 1'b1;
        best_len   <= a_len;
        win_metric <= a_metric;
        lk_hop     <= a_hop;
        lk_dev     <= a_dev;
      end
    end
  end

  assign flags.busy     = a_vld;
  assign flags.add_hit  = add_hit;
  assign flags.free_hit = free_hit;
  assign flags.del_hit  = del_hit;
  assign flags.lk_hit   = lk_hit;

endmodule

### rtl/iprt_chk.sv
// ----------------------------------------------------------------------------
// iprt_chk
// port-level checks of the route table, bound to the top level
// ----------------------------------------------------------------------------
module iprt_chk import iprt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic       req_xfer, rsp_xfer;
  logic [1:0] pend;   // requests taken whose result is not yet transferred

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(req_xfer) - 2'(rsp_xfer);
    end
  end

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one request at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req_ready)
    else $error("request taken while busy");

  // no result without a request behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 2'd0)
    else $error("result without pending request");

  // at most one result waiting and one request in work
  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("too many requests outstanding");

  // failures carry no device
  a_fail_dev: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NOT_FOUND ||
                  rsp.status == ST_NO_ROUTE) |-> rsp.out_device == '0)
    else $error("device set on failed command");

endmodule

bind ip_route_table_lpm_top iprt_chk u_iprt_chk (.*);
